@@ design/oik_pkg.sv @@
// ============================================================================
// oik_pkg
// Shared types and constants for the omni wheel inverse kinematics pipeline.
// ============================================================================
package oik_pkg;

   localparam int MAX_STAGES  = 24;
   localparam int TRIG_WIDTH  = 34;
   localparam int PROD_SHIFT  = 30;
   localparam int RADIUS_FRAC = 16;

   localparam logic [31:0] SIXTH_TURN   = 32'd715827883;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

   // CORDIC gain compensation, Q30
   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;

   // arctan(2^-i) as a fraction of a full turn, 2^32 per turn
   localparam logic [31:0] ATAN_TURNS [MAX_STAGES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef logic signed [TRIG_WIDTH-1:0] trig_type;

   typedef struct packed {
      trig_type x;
      trig_type y;
      trig_type z;
   } cordic_lane_type;

endpackage

@@ design/oik_cordic_stage.sv @@
// ============================================================================
// oik_cordic_stage
// One registered rotation step of a CORDIC lane.
// ============================================================================
module oik_cordic_stage #(
   parameter int STAGE = 0
) (
   input  logic                     clock,
   input  logic                     enable,
   input  oik_pkg::cordic_lane_type lane_i,
   output oik_pkg::cordic_lane_type lane_o
);
   import oik_pkg::*;

   cordic_lane_type lane_ff, lane_in;
   trig_type        x_shift, y_shift, step;

   always_comb begin
      x_shift = lane_i.x >>> STAGE;
      y_shift = lane_i.y >>> STAGE;
      step    = TRIG_WIDTH'(ATAN_TURNS[STAGE]);
      // rotate toward zero residual angle
      if (!lane_i.z[TRIG_WIDTH-1]) begin
         lane_in.x = lane_i.x - y_shift;
         lane_in.y = lane_i.y + x_shift;
         lane_in.z = lane_i.z - step;
      end else begin
         lane_in.x = lane_i.x + y_shift;
         lane_in.y = lane_i.y - x_shift;
         lane_in.z = lane_i.z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

@@ design/oik_wheel.sv @@
// ============================================================================
// oik_wheel
// Multiply, round, sum and clip for one wheel; two register stages.
// ============================================================================
module oik_wheel #(
   parameter bit NEG_SIN = 1'b0,
   parameter bit NEG_COS = 1'b0
) (
   input  logic                 clock,
   input  logic                 enable,
   input  oik_pkg::trig_type    sin_val,
   input  oik_pkg::trig_type    cos_val,
   input  logic signed [31:0]   vel_x,
   input  logic signed [31:0]   vel_y,
   input  logic signed [40:0]   rate_term,
   output logic signed [31:0]   speed,
   output logic                 saturated
);
   import oik_pkg::*;

   localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;
   localparam logic signed [42:0] SPEED_MAX  = 43'sd2147483647;
   localparam logic signed [42:0] SPEED_MIN  = -43'sd2147483648;

   logic signed [65:0] prod_s_ff, prod_c_ff;
   logic signed [65:0] round_s, round_c;
   logic signed [35:0] term_s, term_c;
   logic signed [42:0] part_s, part_c, sum;
   logic signed [31:0] speed_ff, speed_in;
   logic               sat_ff, sat_in;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_s_ff <= vel_x * sin_val;
         prod_c_ff <= vel_y * cos_val;
      end
   end

   always_comb begin
      round_s = (prod_s_ff + ROUND_HALF) >>> PROD_SHIFT;
      round_c = (prod_c_ff + ROUND_HALF) >>> PROD_SHIFT;
      term_s  = round_s[35:0];
      term_c  = round_c[35:0];
      part_s  = NEG_SIN ? -43'(term_s) : 43'(term_s);
      part_c  = NEG_COS ? -43'(term_c) : 43'(term_c);
      sum     = part_s + part_c + 43'(rate_term);
      // clip to the signed 32-bit range
      if (sum > SPEED_MAX) begin
         speed_in = 32'sh7FFF_FFFF;
         sat_in   = 1'b1;
      end else if (sum < SPEED_MIN) begin
         speed_in = 32'sh8000_0000;
         sat_in   = 1'b1;
      end else begin
         speed_in = sum[31:0];
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         speed_ff <= speed_in;
         sat_ff   <= sat_in;
      end
   end

   assign speed     = speed_ff;
   assign saturated = sat_ff;

endmodule

@@ design/omni_wheel_inverse_kinematics.sv @@
// ============================================================================
// omni_wheel_inverse_kinematics
// Three-wheel omni base inverse kinematics, fully pipelined fixed point.
// ============================================================================
// Takes a world-frame velocity command (vx, vy, rate, Q15.16) with the robot
// heading and returns the three wheel speeds (Q15.16, saturated) of a base
// whose wheels sit 120 degrees apart. One command word enters per clock
// while the pipe advances. Each word passes an angle setup register that
// forms the three wheel angles, the CORDIC stages that run three lanes side
// by side, a multiply register, and an output register into which it is
// rounded, summed and clipped. The whole pipe advances together; while a
// result word waits on rsp_ready every stage holds, so nothing is dropped or
// repeated. Write the lever radius (unsigned Q8.16, reset 1.0) over the csr
// port only while the pipe is empty. Heading bits above ANGLE_BITS are ignored.
module omni_wheel_inverse_kinematics #(
   parameter int ANGLE_BITS  = 16,
   parameter int TRIG_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_world_vel_x,
   input  logic signed [31:0] req_world_vel_y,
   input  logic signed [31:0] req_world_rate,
   input  logic [15:0]        req_heading,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_wheel_one_speed,
   output logic signed [31:0] rsp_wheel_two_speed,
   output logic signed [31:0] rsp_wheel_three_speed,
   output logic               rsp_saturated,
   // lever radius register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [23:0]        csr_lever_radius
);
   import oik_pkg::*;

   localparam logic [31:0] ANGLE_MASK = (32'd1 << ANGLE_BITS) - 32'd1;
   localparam int          MUL_STAGE  = TRIG_STAGES + 1;
   localparam logic signed [56:0] RATE_HALF = 57'sd32768;

   logic        advance;
   logic [23:0] lever_radius_ff;

   // valid bit per stage: 0 angle setup, 1..TRIG_STAGES CORDIC, then multiply
   logic [MUL_STAGE:0] valid_ff, valid_in;
   logic               rsp_valid_ff;

   logic [31:0]     turn;
   logic [31:0]     angle [3];
   logic [31:0]     rotated [3];
   logic [2:0]      flip_in;
   cordic_lane_type lane_in [3];
   cordic_lane_type lane_head_ff [3];
   cordic_lane_type lane [TRIG_STAGES+1][3];

   // payload that rides alongside the CORDIC lanes
   logic signed [31:0] vel_x_ff [TRIG_STAGES+1];
   logic signed [31:0] vel_y_ff [TRIG_STAGES+1];
   logic signed [31:0] rate_ff  [TRIG_STAGES+1];
   logic [2:0]         flip_ff  [TRIG_STAGES+1];

   logic signed [31:0] mul_vel_x_ff, mul_vel_y_ff;
   logic signed [56:0] rate_prod_ff;
   logic signed [56:0] rate_round;
   logic signed [40:0] rate_term;
   trig_type           sin_val [3];
   trig_type           cos_val [3];
   logic [2:0]         wheel_sat;

   // the whole pipe moves unless the output word is held
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lever_radius_ff <= 24'd65536;
      end else if (csr_valid) begin
         lever_radius_ff <= csr_lever_radius;
      end
   end

   // wheel angles: heading, sixth turn minus heading, sixth turn plus heading;
   // fold the left half plane onto the right and remember to negate
   always_comb begin
      turn     = (32'(req_heading) & ANGLE_MASK) << (32 - ANGLE_BITS);
      angle[0] = turn;
      angle[1] = SIXTH_TURN - turn;
      angle[2] = SIXTH_TURN + turn;
      for (int j = 0; j < 3; j++) begin
         flip_in[j]   = angle[j][31] ^ angle[j][30];
         rotated[j]   = flip_in[j] ? (angle[j] ^ HALF_TURN) : angle[j];
         lane_in[j].x = CORDIC_GAIN;
         lane_in[j].y = '0;
         lane_in[j].z = {{(TRIG_WIDTH-32){rotated[j][31]}}, rotated[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 3; j++) begin
            lane_head_ff[j] <= lane_in[j];
         end
         vel_x_ff[0] <= req_world_vel_x;
         vel_y_ff[0] <= req_world_vel_y;
         rate_ff[0]  <= req_world_rate;
         flip_ff[0]  <= flip_in;
         for (int k = 1; k <= TRIG_STAGES; k++) begin
            vel_x_ff[k] <= vel_x_ff[k-1];
            vel_y_ff[k] <= vel_y_ff[k-1];
            rate_ff[k]  <= rate_ff[k-1];
            flip_ff[k]  <= flip_ff[k-1];
         end
      end
   end

   assign lane[0] = lane_head_ff;

   for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_stage
      for (genvar j = 0; j < 3; j++) begin : g_lane
         oik_cordic_stage #(
            .STAGE (k)
         ) u_stage (
            .clock  (clock),
            .enable (advance),
            .lane_i (lane[k][j]),
            .lane_o (lane[k+1][j])
         );
      end
   end

   // undo the half-turn fold on the CORDIC outputs
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sin_val[j] = flip_ff[TRIG_STAGES][j] ? -lane[TRIG_STAGES][j].y
                                              : lane[TRIG_STAGES][j].y;
         cos_val[j] = flip_ff[TRIG_STAGES][j] ? -lane[TRIG_STAGES][j].x
                                              : lane[TRIG_STAGES][j].x;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rate_prod_ff <= $signed({1'b0, lever_radius_ff}) * rate_ff[TRIG_STAGES];
      end
   end

   assign mul_vel_x_ff = vel_x_ff[TRIG_STAGES];
   assign mul_vel_y_ff = vel_y_ff[TRIG_STAGES];
   assign rate_round   = (rate_prod_ff + RATE_HALF) >>> RADIUS_FRAC;
   assign rate_term    = rate_round[40:0];

   oik_wheel #(.NEG_SIN(1'b1), .NEG_COS(1'b0)) u_wheel_one (
      .clock     (clock),
      .enable    (advance),
      .sin_val   (sin_val[0]),
      .cos_val   (cos_val[0]),
      .vel_x     (mul_vel_x_ff),
      .vel_y     (mul_vel_y_ff),
      .rate_term (rate_term),
      .speed     (rsp_wheel_one_speed),
      .saturated (wheel_sat[0])
   );

   oik_wheel #(.NEG_SIN(1'b1), .NEG_COS(1'b1)) u_wheel_two (
      .clock     (clock),
      .enable    (advance),
      .sin_val   (sin_val[1]),
      .cos_val   (cos_val[1]),
      .vel_x     (mul_vel_x_ff),
      .vel_y     (mul_vel_y_ff),
      .rate_term (rate_term),
      .speed     (rsp_wheel_two_speed),
      .saturated (wheel_sat[1])
   );

   oik_wheel #(.NEG_SIN(1'b0), .NEG_COS(1'b1)) u_wheel_three (
      .clock     (clock),
      .enable    (advance),
      .sin_val   (sin_val[2]),
      .cos_val   (cos_val[2]),
      .vel_x     (mul_vel_x_ff),
      .vel_y     (mul_vel_y_ff),
      .rate_term (rate_term),
      .speed     (rsp_wheel_three_speed),
      .saturated (wheel_sat[2])
   );

   // advance valid bits with the data
   assign valid_in = {valid_ff[MUL_STAGE-1:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[MUL_STAGE];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_saturated = |wheel_sat;

   // a held result word freezes the intake
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("intake open while result word is held");

   // a held result word keeps the speeds of wheels one and three
   assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid_ff && !rsp_ready) && !$past(reset)
      |-> $stable(rsp_wheel_one_speed) && $stable(rsp_wheel_three_speed))
      else $error("held result word changed");

   // the saturation flag implies some speed sits at a rail
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_saturated |->
         rsp_wheel_one_speed == 32'sh7FFF_FFFF || rsp_wheel_one_speed == 32'sh8000_0000 ||
         rsp_wheel_two_speed == 32'sh7FFF_FFFF || rsp_wheel_two_speed == 32'sh8000_0000 ||
         rsp_wheel_three_speed == 32'sh7FFF_FFFF ||
         rsp_wheel_three_speed == 32'sh8000_0000)
      else $error("saturation flag without a clipped speed");

endmodule
